// ===== design/ipd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the isolated pixel detector.
// No dependencies; ipd_out_if and the detector top import this package.
package ipd_pkg;

  localparam int ROW_W   = 12;
  localparam int COL_W   = 10;
  localparam int TOTAL_W = 20;
  localparam int CFG_W   = 13;
  localparam int ROWS_W  = 13;
  localparam int COLS_W  = 11;

  localparam logic [TOTAL_W-1:0] COUNT_MAX = '1;

  // Window layout: bits 8..6 two columns left, 5..3 one left, 2..0 current.
  // An island is a lone set bit in the middle of the middle column.
  localparam logic [8:0] ISLAND_PATTERN = 9'h010;

  // Depth of the result queue; the input stalls unless there is room for two words
  // for each pixel in flight, the one in the window stage and the one entering it.
  localparam int QDEPTH = 8;

  typedef enum logic {
    CFG_FRAME_ROWS = 1'b0,
    CFG_FRAME_COLS = 1'b1
  } cfg_index_t;

  typedef enum logic {
    KIND_ISLAND = 1'b0,
    KIND_TOTAL  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ROW_W-1:0]   island_row;
    logic [COL_W-1:0]   island_col;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } result_t;

endpackage

// ===== design/ipd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the isolated pixel detector: pixel input and results.
// Depends on ipd_pkg for the field widths.
interface ipd_in_if;
  logic valid;
  logic ready;
  logic pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface ipd_out_if
  import ipd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [ROW_W-1:0]   island_row;
  logic [COL_W-1:0]   island_col;
  logic [TOTAL_W-1:0] total;
  logic               last;

  modport source (output valid, output kind, output island_row, output island_col,
                  output total, output last, input ready);
  modport sink   (input valid, input kind, input island_row, input island_col,
                  input total, input last, output ready);
endinterface

// ===== design/ipd_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Reads return the old contents when read and write hit the same address.
module ipd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/isolated_pixel_detector_top.sv =====
`timescale 1ns / 1ps
// Isolated pixel detector: takes one binary pixel per clock in raster order and
// reports every interior 1-pixel whose eight neighbors are 0, then a frame total
// word with last set after the final pixel. A pixel is accepted every cycle as
// long as the eight-word result queue has room; a pixel's results go through the
// window stage into the queue. The two previous rows live in one 2-bit wide line
// memory, read when a pixel is taken and written back on the next cycle; with a
// one-column frame the pending write is forwarded. Writing frame_rows or
// frame_cols restarts the frame. Depends on ipd_pkg, ipd_if and ipd_ram.
module isolated_pixel_detector_top
  import ipd_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  ipd_in_if.sink           in_ch,
  ipd_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CW   = $clog2(MAX_COLS);
  localparam int CW1  = $clog2(MAX_COLS + 1);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int RW1  = $clog2(MAX_ROWS + 1);
  localparam int PW   = $clog2(QDEPTH);
  localparam int QCW  = $clog2(QDEPTH + 1);

  // Effective frame size, clamped when written.
  logic [RW1-1:0] eff_rows_r;
  logic [CW1-1:0] eff_cols_r;
  logic [ROWS_W-1:0] rows_in;
  logic [COLS_W-1:0] cols_in;

  // Position of the next pixel.
  logic [CW-1:0] col_pos_r, col_pos_nxt;
  logic [RW-1:0] row_pos_r, row_pos_nxt;

  // Window stage.
  logic          s1_valid_r;
  logic          s1_pixel_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s1_end_r;
  logic          fwd_hit_r;
  logic [1:0]    fwd_data_r;
  logic [5:0]    window_r, window_nxt;
  logic [TOTAL_W-1:0] count_r, count_nxt;

  // Result queue.
  result_t        queue_r [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] q_count_r;

  logic          accept;
  logic          last_col, last_row, frame_end;
  logic [1:0]    ram_rdata;
  logic [1:0]    line;
  logic [1:0]    line_wdata;
  logic [2:0]    colbits;
  logic          interior;
  logic          hit;
  result_t       isl_res, tot_res;
  logic          pop;
  logic [1:0]    push_n;
  logic [QCW:0]  q_need;

  assign rows_in = cfg_data[ROWS_W-1:0];
  assign cols_in = cfg_data[COLS_W-1:0];

  assign accept = in_ch.valid && in_ch.ready;

  // Line memory: bit 1 is the row two up, bit 0 the row one up.
  ipd_ram #(
    .WIDTH (2),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (line_wdata),
    .raddr (col_pos_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    last_col  = (CW1'(col_pos_r) == eff_cols_r - CW1'(1));
    last_row  = (RW1'(row_pos_r) == eff_rows_r - RW1'(1));
    frame_end = last_col && last_row;
    if (last_col) begin
      col_pos_nxt = '0;
      row_pos_nxt = last_row ? '0 : row_pos_r + RW'(1);
    end else begin
      col_pos_nxt = col_pos_r + CW'(1);
      row_pos_nxt = row_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_rows_r <= RW1'(1);
      eff_cols_r <= CW1'(1);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FRAME_ROWS: begin
          if (rows_in == '0) begin
            eff_rows_r <= RW1'(1);
          end else if (32'(rows_in) > MAX_ROWS) begin
            eff_rows_r <= RW1'(MAX_ROWS);
          end else begin
            eff_rows_r <= RW1'(rows_in);
          end
        end
        CFG_FRAME_COLS: begin
          if (cols_in == '0) begin
            eff_cols_r <= CW1'(1);
          end else if (32'(cols_in) > MAX_COLS) begin
            eff_cols_r <= CW1'(MAX_COLS);
          end else begin
            eff_cols_r <= CW1'(cols_in);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Window evaluation on the word read back from the line memory.
  always_comb begin
    line       = fwd_hit_r ? fwd_data_r : ram_rdata;
    colbits    = {line[1], line[0], s1_pixel_r};
    line_wdata = {line[0], s1_pixel_r};
    interior   = (s1_row_r >= RW'(2)) && (s1_col_r >= CW'(2));
    hit        = s1_valid_r && interior && ({window_r, colbits} == ISLAND_PATTERN);

    count_nxt = count_r;
    if (hit && count_r != COUNT_MAX) begin
      count_nxt = count_r + TOTAL_W'(1);
    end

    isl_res.kind       = KIND_ISLAND;
    isl_res.island_row = ROW_W'(s1_row_r - RW'(1));
    isl_res.island_col = COL_W'(s1_col_r - CW'(1));
    isl_res.total      = count_nxt;
    isl_res.last       = 1'b0;

    tot_res.kind       = KIND_TOTAL;
    tot_res.island_row = '0;
    tot_res.island_col = '0;
    tot_res.total      = count_nxt;
    tot_res.last       = 1'b1;

    window_nxt = {window_r[2:0], colbits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      s1_valid_r <= 1'b0;
      window_r   <= '0;
      count_r    <= '0;
    end else if (cfg_we) begin
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      s1_valid_r <= 1'b0;
      window_r   <= '0;
      count_r    <= '0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        col_pos_r <= col_pos_nxt;
        row_pos_r <= row_pos_nxt;
      end
      if (s1_valid_r) begin
        window_r <= s1_end_r ? '0 : window_nxt;
        count_r  <= s1_end_r ? '0 : count_nxt;
      end
    end
  end

  // Stage payload; the forward covers a read of the column being written now.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel_r <= in_ch.pixel;
      s1_col_r   <= col_pos_r;
      s1_row_r   <= row_pos_r;
      s1_end_r   <= frame_end;
      fwd_hit_r  <= s1_valid_r && (s1_col_r == col_pos_r);
      fwd_data_r <= line_wdata;
    end
  end

  // Result queue: up to two words pushed per pixel, one popped per cycle when the output is ready.
  assign pop    = out_ch.valid && out_ch.ready;
  assign push_n = s1_valid_r ? ({1'b0, hit} + {1'b0, s1_end_r}) : 2'd0;
  assign q_need = (QCW + 1)'(q_count_r) + (s1_valid_r ? (QCW + 1)'(2) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      q_count_r <= '0;
    end else begin
      wr_ptr_r  <= wr_ptr_r + PW'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      q_count_r <= q_count_r + QCW'(push_n) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      if (hit) begin
        queue_r[wr_ptr_r] <= isl_res;
      end
      if (s1_end_r) begin
        queue_r[wr_ptr_r + PW'(hit)] <= tot_res;
      end
    end
  end

  // Room for the words of the pixel in the window stage and of the one entering it.
  assign in_ch.ready = (q_need <= (QCW + 1)'(QDEPTH - 2));

  assign out_ch.valid      = (q_count_r != '0);
  assign out_ch.kind       = queue_r[rd_ptr_r].kind;
  assign out_ch.island_row = queue_r[rd_ptr_r].island_row;
  assign out_ch.island_col = queue_r[rd_ptr_r].island_col;
  assign out_ch.total      = queue_r[rd_ptr_r].total;
  assign out_ch.last       = queue_r[rd_ptr_r].last;

endmodule
